/* hw/rtl/rfw_pkg.sv */
// rfw_pkg: shared types, widths, register indexes and reset values for the
// RGB-D forward warp. No dependencies.
`default_nettype none

package rfw_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int DEPTH_W        = 24;
	localparam int SCALE_W        = 32;
	localparam int DEPTH_PROD_W   = DEPTH_W + SCALE_W;
	localparam int CFG_DATA_W     = 64;
	localparam int CHAN_W         = 16;

	typedef logic signed [31:0]       coef_t;
	typedef logic [CHAN_W-1:0]        chan_t;
	typedef logic [2:0]               cfg_idx_t;

	localparam cfg_idx_t REG_M00_M01    = 3'd0;
	localparam cfg_idx_t REG_M02_M10    = 3'd1;
	localparam cfg_idx_t REG_M11_M12    = 3'd2;
	localparam cfg_idx_t REG_M20_M21    = 3'd3;
	localparam cfg_idx_t REG_M22_T0     = 3'd4;
	localparam cfg_idx_t REG_T1_T2      = 3'd5;
	localparam cfg_idx_t REG_DEPTH_SCALE = 3'd6;
	localparam cfg_idx_t REG_IMAGE_SIZE = 3'd7;

	localparam logic [63:0] RST_M00_M01     = 64'd65536;
	localparam logic [63:0] RST_M02_M10     = 64'd0;
	localparam logic [63:0] RST_M11_M12     = 64'd65536;
	localparam logic [63:0] RST_M20_M21     = 64'd0;
	localparam logic [63:0] RST_M22_T0      = 64'd65536;
	localparam logic [63:0] RST_T1_T2       = 64'd0;
	localparam logic [31:0] RST_DEPTH_SCALE = 32'd65536;
	localparam logic [31:0] RST_IMAGE_SIZE  = 32'd31457920;

	// width of the row sum A*(x,y,1) in Q.16
	function automatic int sum_w(int cb);
		return cb + 35;
	endfunction

	// width of a homogeneous component in Q.48
	function automatic int pos_w(int cb);
		return cb + 92;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rfw_pix_if.sv */
// rfw_pix_if: input pixel channel (valid/ready plus source pixel payload).
// Depends on rfw_pkg.
`default_nettype none

interface rfw_pix_if import rfw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pix_x;
	logic [COORD_BITS-1:0] pix_y;
	logic [DEPTH_W-1:0]    depth;
	chan_t                 red_in;
	chan_t                 green_in;
	chan_t                 blue_in;

	modport source(output valid, pix_x, pix_y, depth, red_in, green_in, blue_in,
		input ready);
	modport sink(input valid, pix_x, pix_y, depth, red_in, green_in, blue_in,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/rfw_wr_if.sv */
// rfw_wr_if: output write channel (valid/ready plus destination write payload).
// Depends on rfw_pkg.
`default_nettype none

interface rfw_wr_if import rfw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [COORD_BITS-1:0] dst_x;
	logic [COORD_BITS-1:0] dst_y;
	chan_t                 red_out;
	chan_t                 green_out;
	chan_t                 blue_out;

	modport source(output valid, write_enable, dst_x, dst_y, red_out, green_out,
		blue_out, input ready);
	modport sink(input valid, write_enable, dst_x, dst_y, red_out, green_out,
		blue_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rfw_proj.sv */
// rfw_proj: five-stage projection pipeline, p = A*(x,y,1)*depth*scale + t<<32.
// Depends on rfw_pkg.
`default_nettype none

module rfw_proj import rfw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TAG_W      = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [TAG_W-1:0]               in_tag,
	input  logic [COORD_BITS-1:0]          x,
	input  logic [COORD_BITS-1:0]          y,
	input  logic [DEPTH_W-1:0]             depth,
	input  coef_t                          a00, a01, a02,
	input  coef_t                          a10, a11, a12,
	input  coef_t                          a20, a21, a22,
	input  coef_t                          t0, t1, t2,
	input  logic [SCALE_W-1:0]             scale,
	output logic                           out_valid,
	output logic [TAG_W-1:0]               out_tag,
	output logic signed [pos_w(COORD_BITS)-1:0] px,
	output logic signed [pos_w(COORD_BITS)-1:0] py,
	output logic signed [pos_w(COORD_BITS)-1:0] pz
);
	localparam int MW = COORD_BITS + 33;
	localparam int VW = sum_w(COORD_BITS);
	localparam int PW = pos_w(COORD_BITS);
	localparam int VL = VW / 2;
	localparam int VH = VW - VL;
	localparam int DL = DEPTH_PROD_W / 2;
	localparam int DH = DEPTH_PROD_W - DL;

	logic signed [COORD_BITS:0] xs, ys;
	coef_t ac [3];
	coef_t tv [3];

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [TAG_W-1:0]        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [MW-1:0]    mx_s1 [3];
	logic signed [MW-1:0]    my_s1 [3];
	logic [DEPTH_PROD_W-1:0] d_s1, d_s2;
	logic signed [VW-1:0]    v_s2 [3];
	logic [VL+DL-1:0]        ll_s3 [3];
	logic [VL+DH-1:0]        lh_s3 [3];
	logic signed [VH+DL:0]   hl_s3 [3];
	logic signed [VH+DH:0]   hh_s3 [3];
	logic signed [PW-1:0]    a_s4 [3];
	logic signed [PW-1:0]    b_s4 [3];
	logic signed [PW-1:0]    p_s5 [3];

	assign xs = $signed({1'b0, x});
	assign ys = $signed({1'b0, y});
	assign ac[0] = a02;
	assign ac[1] = a12;
	assign ac[2] = a22;
	assign tv[0] = t0;
	assign tv[1] = t1;
	assign tv[2] = t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: coefficient times coordinate, scaled depth
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1   <= in_tag;
			mx_s1[0] <= a00 * xs;
			my_s1[0] <= a01 * ys;
			mx_s1[1] <= a10 * xs;
			my_s1[1] <= a11 * ys;
			mx_s1[2] <= a20 * xs;
			my_s1[2] <= a21 * ys;
			d_s1     <= depth * scale;
			tag_s2   <= tag_s1;
			d_s2     <= d_s1;
			tag_s3   <= tag_s2;
			tag_s4   <= tag_s3;
			tag_s5   <= tag_s4;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_comp
		logic [VL-1:0]        vlo;
		logic signed [VH-1:0] vhi;
		logic [DL-1:0]        dlo;
		logic [DH-1:0]        dhi;
		logic signed [PW-1:0] tll, tlh, thl, thh, tt;

		assign vlo = v_s2[c][VL-1:0];
		assign vhi = $signed(v_s2[c][VW-1:VL]);
		assign dlo = d_s2[DL-1:0];
		assign dhi = d_s2[DEPTH_PROD_W-1:DL];
		// unsigned partials zero extend, signed ones sign extend
		assign tll = ll_s3[c];
		assign tlh = lh_s3[c];
		assign thl = hl_s3[c];
		assign thh = hh_s3[c];
		assign tt  = tv[c];

		always_ff @(posedge clk) begin
			if (en) begin
				// stage 2: row sum
				v_s2[c]  <= mx_s1[c] + my_s1[c] + ac[c];
				// stage 3: four partial products
				ll_s3[c] <= vlo * dlo;
				lh_s3[c] <= vlo * dhi;
				hl_s3[c] <= vhi * $signed({1'b0, dlo});
				hh_s3[c] <= vhi * $signed({1'b0, dhi});
				// stage 4: pairwise partial sums
				a_s4[c]  <= tll + (tlh <<< DL);
				b_s4[c]  <= (thl <<< VL) + (thh <<< (VL + DL));
				// stage 5: add offset in Q.48
				p_s5[c]  <= a_s4[c] + b_s4[c] + (tt <<< 32);
			end
		end
	end

	assign out_valid = vld_s5;
	assign out_tag   = tag_s5;
	assign px        = p_s5[0];
	assign py        = p_s5[1];
	assign pz        = p_s5[2];

endmodule

`default_nettype wire

/* hw/rtl/rfw_div.sv */
// rfw_div: range check and bit-per-stage restoring divider for the rounded
// quotients (2p+pz)/(2pz) of both coordinates. Depends on rfw_pkg.
`default_nettype none

module rfw_div import rfw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TAG_W      = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [TAG_W-1:0]                    in_tag,
	input  logic signed [pos_w(COORD_BITS)-1:0] px,
	input  logic signed [pos_w(COORD_BITS)-1:0] py,
	input  logic signed [pos_w(COORD_BITS)-1:0] pz,
	output logic                                out_valid,
	output logic [TAG_W-1:0]                    out_tag,
	output logic                                out_ok,
	output logic [COORD_BITS-1:0]               qx,
	output logic [COORD_BITS-1:0]               qy
);
	localparam int PW = pos_w(COORD_BITS);
	localparam int NW = PW + COORD_BITS + 2;
	localparam int UW = NW - 1;
	localparam int NS = COORD_BITS + 1;

	logic signed [NW-1:0] pzw, den, den_max;
	logic signed [NW-1:0] pw  [2];
	logic signed [NW-1:0] num [2];
	logic                 in_range;

	logic                  vld_s [NS];
	logic [TAG_W-1:0]      tag_s [NS];
	logic                  ok_s  [NS];
	logic [UW-1:0]         den_s [NS];
	logic [UW-1:0]         rem_s [NS][2];
	logic [COORD_BITS-1:0] q_s   [NS][2];

	assign pzw     = pz;
	assign pw[0]   = px;
	assign pw[1]   = py;
	assign num[0]  = (pw[0] <<< 1) + pzw;
	assign num[1]  = (pw[1] <<< 1) + pzw;
	assign den     = pzw <<< 1;
	assign den_max = den <<< COORD_BITS;
	// quotient must land in [1, 2^COORD_BITS) and the point must be in front
	assign in_range = (pzw > 0) && (num[0] >= den) && (num[0] < den_max)
		&& (num[1] >= den) && (num[1] < den_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0]    <= in_tag;
			ok_s[0]     <= in_range;
			den_s[0]    <= den[UW-1:0];
			rem_s[0][0] <= num[0][UW-1:0];
			rem_s[0][1] <= num[1][UW-1:0];
			q_s[0][0]   <= '0;
			q_s[0][1]   <= '0;
		end
	end

	for (genvar k = 0; k < COORD_BITS; k++) begin : g_bit
		localparam int B = COORD_BITS - 1 - k;
		logic [UW-1:0] sub;

		assign sub = den_s[k] << B;

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= tag_s[k];
				ok_s[k+1]  <= ok_s[k];
				den_s[k+1] <= den_s[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic                  ge;
			logic [COORD_BITS-1:0] qn;

			assign ge = rem_s[k][l] >= sub;
			always_comb begin
				qn    = q_s[k][l];
				qn[B] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? rem_s[k][l] - sub : rem_s[k][l];
					q_s[k+1][l]   <= qn;
				end
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_tag   = tag_s[NS-1];
	assign out_ok    = ok_s[NS-1];
	assign qx        = q_s[NS-1][0];
	assign qy        = q_s[NS-1][1];

endmodule

`default_nettype wire

/* hw/rtl/rgbd_forward_warp.sv */
// rgbd_forward_warp: top level of the RGB-D forward warp, configuration
// registers and output register. Depends on rfw_pkg, rfw_pix_if, rfw_wr_if,
// rfw_proj and rfw_div.
//
// Forward-warps one RGB-D pixel per clock. Each pixel transfer on pix yields
// exactly one transfer on wr, in order; write_enable says whether the colour
// should land at (dst_x, dst_y), otherwise all result fields are zero.
// The pipeline is five projection stages (coordinate products, row sums,
// partial products of the 56-bit scaled depth, two add stages), one
// range-check stage, one restoring-divider stage per destination coordinate
// bit, and the output register. The pipeline takes a new pixel every cycle
// while wr is not stalled; a stall freezes every stage.
// Config registers are written through cfg_we/cfg_idx/cfg_data and must only
// change while the pipeline is empty.
`default_nettype none

module rgbd_forward_warp import rfw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rfw_pix_if.sink               pix,
	rfw_wr_if.source              wr
);
	localparam int PW    = pos_w(COORD_BITS);
	localparam int TAG_W = 1 + 3 * CHAN_W;

	// config registers
	logic [63:0] m00_m01_q, m02_m10_q, m11_m12_q, m20_m21_q, m22_t0_q, t1_t2_q;
	logic [31:0] scale_q, size_q;

	logic                  en;
	logic [TAG_W-1:0]      in_tag, proj_tag, div_tag;
	logic                  proj_valid, div_valid, div_ok;
	logic signed [PW-1:0]  px, py, pz;
	logic [COORD_BITS-1:0] qx, qy;
	logic [16:0]           qx_ext, qy_ext, w_ext, h_ext;
	logic                  hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m00_m01_q <= RST_M00_M01;
			m02_m10_q <= RST_M02_M10;
			m11_m12_q <= RST_M11_M12;
			m20_m21_q <= RST_M20_M21;
			m22_t0_q  <= RST_M22_T0;
			t1_t2_q   <= RST_T1_T2;
			scale_q   <= RST_DEPTH_SCALE;
			size_q    <= RST_IMAGE_SIZE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_M00_M01:     m00_m01_q <= cfg_data;
				REG_M02_M10:     m02_m10_q <= cfg_data;
				REG_M11_M12:     m11_m12_q <= cfg_data;
				REG_M20_M21:     m20_m21_q <= cfg_data;
				REG_M22_T0:      m22_t0_q  <= cfg_data;
				REG_T1_T2:       t1_t2_q   <= cfg_data;
				REG_DEPTH_SCALE: scale_q   <= cfg_data[31:0];
				REG_IMAGE_SIZE:  size_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a finished result is held by wr
	assign en        = !wr.valid || wr.ready;
	assign pix.ready = en;

	// tag rides along: depth-present flag and the colour
	assign in_tag = {pix.depth != '0, pix.red_in, pix.green_in, pix.blue_in};

	rfw_proj #(
		.COORD_BITS(COORD_BITS),
		.TAG_W     (TAG_W)
	) u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pix.valid),
		.in_tag   (in_tag),
		.x        (pix.pix_x),
		.y        (pix.pix_y),
		.depth    (pix.depth),
		.a00      (m00_m01_q[31:0]),
		.a01      (m00_m01_q[63:32]),
		.a02      (m02_m10_q[31:0]),
		.a10      (m02_m10_q[63:32]),
		.a11      (m11_m12_q[31:0]),
		.a12      (m11_m12_q[63:32]),
		.a20      (m20_m21_q[31:0]),
		.a21      (m20_m21_q[63:32]),
		.a22      (m22_t0_q[31:0]),
		.t0       (m22_t0_q[63:32]),
		.t1       (t1_t2_q[31:0]),
		.t2       (t1_t2_q[63:32]),
		.scale    (scale_q),
		.out_valid(proj_valid),
		.out_tag  (proj_tag),
		.px       (px),
		.py       (py),
		.pz       (pz)
	);

	rfw_div #(
		.COORD_BITS(COORD_BITS),
		.TAG_W     (TAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (proj_valid),
		.in_tag   (proj_tag),
		.px       (px),
		.py       (py),
		.pz       (pz),
		.out_valid(div_valid),
		.out_tag  (div_tag),
		.out_ok   (div_ok),
		.qx       (qx),
		.qy       (qy)
	);

	// bound test; quotient is below 2^COORD_BITS, so an oversized width
	// or height needs no clamp
	assign qx_ext = {{(17 - COORD_BITS){1'b0}}, qx};
	assign qy_ext = {{(17 - COORD_BITS){1'b0}}, qy};
	assign w_ext  = {1'b0, size_q[15:0]};
	assign h_ext  = {1'b0, size_q[31:16]};
	assign hit    = div_ok && div_tag[TAG_W-1] && (qx_ext < w_ext) && (qy_ext < h_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr.valid <= 1'b0;
		end else if (en) begin
			wr.valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr.write_enable <= hit;
			wr.dst_x        <= hit ? qx : '0;
			wr.dst_y        <= hit ? qy : '0;
			wr.red_out      <= hit ? div_tag[3*CHAN_W-1:2*CHAN_W] : '0;
			wr.green_out    <= hit ? div_tag[2*CHAN_W-1:CHAN_W] : '0;
			wr.blue_out     <= hit ? div_tag[CHAN_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

/* tb/rfw_warp_checker.sv */
// rfw_warp_checker: watches the pixel and write channels of the RGB-D forward warp,
// predicts each write from its own copy of the config registers and compares.
// Depends on rfw_pkg, rfw_pix_if and rfw_wr_if.
`default_nettype none

module rfw_warp_checker import rfw_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rfw_pix_if                    pix,
	rfw_wr_if                     wr,
	output int                    errors,
	output int                    pending
);

	typedef logic signed [159:0] big_t;

	typedef struct packed {
		logic          we;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		chan_t         r;
		chan_t         g;
		chan_t         b;
	} wr_item_t;

	logic [63:0] warp_regs [8];
	wr_item_t    expected_writes [$];

	// homogeneous component in Q.48: (c0*x + c1*y + c2) * d + (t << 32)
	function automatic big_t homog(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
			logic [31:0] tt, logic [CB-1:0] x, logic [CB-1:0] y, logic [55:0] d);
		longint row;
		big_t   rw;
		big_t   dw;
		big_t   tw;
		row = longint'($signed(c0)) * longint'(x) + longint'($signed(c1)) * longint'(y)
			+ longint'($signed(c2));
		rw = row;
		dw = {104'b0, d};
		tw = $signed(tt);
		return rw * dw + (tw <<< 32);
	endfunction

	// round p/pz to nearest; valid only when 1 <= q < lim
	function automatic logic round_coord(big_t p, big_t pz, int lim, output logic [CB-1:0] q);
		big_t num;
		big_t den;
		big_t lw;
		q = '0;
		if (2 * p - pz < 0)
			return 1'b0;
		num = 2 * p + pz;
		den = 2 * pz;
		lw = lim;
		if (num >= den * lw)
			return 1'b0;
		q = CB'(num / den);
		return 1'b1;
	endfunction

	function automatic wr_item_t warp_pixel(logic [CB-1:0] x, logic [CB-1:0] y,
			logic [DEPTH_W-1:0] depth, chan_t r, chan_t g, chan_t b);
		wr_item_t    res;
		logic [55:0] d;
		big_t        px;
		big_t        py;
		big_t        pz;
		int          wlim;
		int          hlim;
		logic        okx;
		logic        oky;
		logic [CB-1:0] qx;
		logic [CB-1:0] qy;
		res = '0;
		wlim = warp_regs[REG_IMAGE_SIZE][15:0];
		hlim = warp_regs[REG_IMAGE_SIZE][31:16];
		if (wlim > (1 << CB)) wlim = 1 << CB;
		if (hlim > (1 << CB)) hlim = 1 << CB;
		if (depth == 0)
			return res;
		d = depth * warp_regs[REG_DEPTH_SCALE][31:0];
		px = homog(warp_regs[REG_M00_M01][31:0], warp_regs[REG_M00_M01][63:32],
			warp_regs[REG_M02_M10][31:0], warp_regs[REG_M22_T0][63:32], x, y, d);
		py = homog(warp_regs[REG_M02_M10][63:32], warp_regs[REG_M11_M12][31:0],
			warp_regs[REG_M11_M12][63:32], warp_regs[REG_T1_T2][31:0], x, y, d);
		pz = homog(warp_regs[REG_M20_M21][31:0], warp_regs[REG_M20_M21][63:32],
			warp_regs[REG_M22_T0][31:0], warp_regs[REG_T1_T2][63:32], x, y, d);
		if (pz <= 0)
			return res;
		okx = round_coord(px, pz, wlim, qx);
		oky = round_coord(py, pz, hlim, qy);
		if (okx && oky) begin
			res.we = 1'b1;
			res.x = qx;
			res.y = qy;
			res.r = r;
			res.g = g;
			res.b = b;
		end
		return res;
	endfunction

	assign pending = expected_writes.size();

	always @(posedge clk or negedge arst_n) begin
		wr_item_t got;
		wr_item_t want;
		if (!arst_n) begin
			warp_regs[REG_M00_M01]     <= RST_M00_M01;
			warp_regs[REG_M02_M10]     <= RST_M02_M10;
			warp_regs[REG_M11_M12]     <= RST_M11_M12;
			warp_regs[REG_M20_M21]     <= RST_M20_M21;
			warp_regs[REG_M22_T0]      <= RST_M22_T0;
			warp_regs[REG_T1_T2]       <= RST_T1_T2;
			warp_regs[REG_DEPTH_SCALE] <= {32'b0, RST_DEPTH_SCALE};
			warp_regs[REG_IMAGE_SIZE]  <= {32'b0, RST_IMAGE_SIZE};
			expected_writes.delete();
			errors <= 0;
		end else begin
			if (cfg_we)
				warp_regs[cfg_idx] <= (cfg_idx < REG_DEPTH_SCALE) ? cfg_data
					: {32'b0, cfg_data[31:0]};
			if (pix.valid && pix.ready)
				expected_writes.insert(expected_writes.size(),
					warp_pixel(pix.pix_x, pix.pix_y, pix.depth,
					pix.red_in, pix.green_in, pix.blue_in));
			if (wr.valid && wr.ready) begin
				got = '{wr.write_enable, wr.dst_x, wr.dst_y, wr.red_out, wr.green_out,
					wr.blue_out};
				if (expected_writes.size() == 0) begin
					$display("%0t: unexpected write transfer, actual %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_writes.pop_front();
					if (got !== want) begin
						$display("%0t: write mismatch, expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* tb/rgbd_forward_warp_tb.sv */
// rgbd_forward_warp_tb: stimulus, config phases and verdict for the RGB-D forward warp.
// Depends on rfw_pkg, rfw_pix_if, rfw_wr_if, rgbd_forward_warp and rfw_warp_checker.
`default_nettype none

module rgbd_forward_warp_tb import rfw_pkg::*;;

	localparam int CB         = COORD_BITS_DEF;
	localparam int IDLE_LIMIT = 20000;   // cycles without any transfer
	localparam int DRAIN_WAIT = 40;      // longer than the pipeline latency
	localparam int LONG_HOLD  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    idle_cycles;
	logic                  burst;      // no idling on either side
	logic                  hold_req;   // receiver long hold-off request

	rfw_pix_if #(.COORD_BITS(CB)) pix_ch ();
	rfw_wr_if  #(.COORD_BITS(CB)) wr_ch ();

	rgbd_forward_warp #(.COORD_BITS(CB)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .pix(pix_ch), .wr(wr_ch)
	);

	rfw_warp_checker #(.CB(CB)) u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .pix(pix_ch), .wr(wr_ch), .errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 70) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// watchdog: stalls with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver: random ready, plus one long hold-off counted here
	initial begin
		wr_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int n;
			if (hold_req) begin
				wr_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = gap_len();
				if (n == 0) begin
					wr_ch.ready <= 1'b1;
					@(posedge clk);
				end else begin
					wr_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays high across back-to-back transfers
	task automatic send_pixel(logic [CB-1:0] x, logic [CB-1:0] y, logic [DEPTH_W-1:0] d,
			chan_t r, chan_t g, chan_t b);
		int n;
		n = gap_len();
		if (n > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.pix_x    <= x;
		pix_ch.pix_y    <= y;
		pix_ch.depth    <= d;
		pix_ch.red_in   <= r;
		pix_ch.green_in <= g;
		pix_ch.blue_in  <= b;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// sender goes quiet until every expected write has arrived
	task automatic drain();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] near(int base, int spread);
		return base + $urandom_range(0, 2 * spread) - spread;
	endfunction

	// well-formed pixel: inside the image, nonzero depth, now and then anything at all
	task automatic random_pixel(int w, int h);
		int r;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [DEPTH_W-1:0] d;
		r = $urandom_range(0, 99);
		if (r < 15 || w < 2 || h < 2) begin
			x = CB'($urandom);
			y = CB'($urandom);
		end else begin
			x = CB'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
			y = CB'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
		end
		d = (r > 94) ? '0 : DEPTH_W'($urandom_range(1, 24'hFFFFFF));
		send_pixel(x, y, d, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
	endtask

	initial begin
		int w;
		int h;
		int mode;
		logic [31:0] a22;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_M00_M01;
		cfg_data = '0;
		burst = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		pix_ch.valid = 1'b0;
		pix_ch.pix_x = '0;
		pix_ch.pix_y = '0;
		pix_ch.depth = '0;
		pix_ch.red_in = '0;
		pix_ch.green_in = '0;
		pix_ch.blue_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config (identity, 640 x 480): edges of the image and fields
		send_pixel(10, 10, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);       // zero depth
		send_pixel(0, 5, 24'h010000, 16'h1234, 16'h5678, 16'h9ABC); // column 0
		send_pixel(1, 1, 24'h010000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_pixel(639, 479, 24'hFFFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		send_pixel(640, 100, 24'h000001, 16'hAAAA, 16'h5555, 16'hAAAA); // just outside
		send_pixel(100, 480, 24'h800000, 16'h5555, 16'hAAAA, 16'h5555);
		send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(5, 0, 24'h000001, 16'h0001, 16'h0002, 16'h0003);
		drain();

		// point behind the camera, then on the camera plane
		write_reg(REG_M22_T0, 64'h0000_0000_FFFF_0000);
		send_pixel(20, 20, 24'h010000, 16'h1111, 16'h2222, 16'h3333);
		drain();
		write_reg(REG_M22_T0, 64'h0);
		send_pixel(20, 20, 24'h010000, 16'h1111, 16'h2222, 16'h3333);
		drain();

		// half-pixel shift for rounding ties, translation only in x and y
		write_reg(REG_M22_T0, 64'h0000_8000_0001_0000);
		write_reg(REG_T1_T2, 64'h0000_0000_FFFF_8000);
		write_reg(REG_IMAGE_SIZE, 32'hFFFF_FFFF);
		send_pixel(3, 3, 24'h010000, 16'h4444, 16'h5555, 16'h6666);
		send_pixel(4094, 4094, 24'h010000, 16'h7777, 16'h8888, 16'h9999);
		send_pixel(4095, 1, 24'h010000, 16'h7777, 16'h8888, 16'h9999);
		drain();
		write_reg(REG_IMAGE_SIZE, 32'h0);
		send_pixel(3, 3, 24'h010000, 16'h4444, 16'h5555, 16'h6666);
		drain();

		// register extremes
		write_reg(REG_M00_M01, 64'h8000_0000_7FFF_FFFF);
		write_reg(REG_M02_M10, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_M11_M12, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_M20_M21, 64'h0000_0001_7FFF_FFFF);
		write_reg(REG_M22_T0, 64'h8000_0000_7FFF_FFFF);
		write_reg(REG_T1_T2, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_DEPTH_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_IMAGE_SIZE, 32'h1000_1000);
		send_pixel(12'hFFF, 0, 24'hFFFFFF, 16'h0F0F, 16'hF0F0, 16'h0F0F);
		send_pixel(0, 12'hFFF, 24'h000001, 16'hF0F0, 16'h0F0F, 16'hF0F0);
		drain();
		write_reg(REG_DEPTH_SCALE, 32'h0);
		send_pixel(7, 7, 24'hFFFFFF, 16'h1111, 16'h1111, 16'h1111);
		drain();

		// random phases: each one writes every register, then streams pixels
		for (int ph = 0; ph < 12; ph++) begin
			mode = (ph % 6 == 5) ? 1 : (ph % 6 == 4 ? 2 : 0);
			burst = (ph == 3 || ph == 8);
			case (mode)
				0: begin
					// near identity, small perspective and offsets
					w = $urandom_range(2, 1200);
					h = $urandom_range(2, 1200);
					a22 = near(65536, 8000);
					write_reg(REG_M00_M01, {near(0, 3000), near(65536, 6000)});
					write_reg(REG_M02_M10, {near(0, 3000), near(0, 40 << 16)});
					write_reg(REG_M11_M12, {near(0, 40 << 16), near(65536, 6000)});
					write_reg(REG_M20_M21, {near(0, 8), near(0, 8)});
					write_reg(REG_M22_T0, {near(0, 20 << 16), a22});
					write_reg(REG_T1_T2, {near(0, 4 << 16), near(0, 20 << 16)});
					write_reg(REG_DEPTH_SCALE, near(65536, 30000));
					write_reg(REG_IMAGE_SIZE, {16'(h), 16'(w)});
				end
				1: begin
					// anything goes
					w = $urandom_range(0, 65535);
					h = $urandom_range(0, 65535);
					write_reg(REG_M00_M01, {$urandom, $urandom});
					write_reg(REG_M02_M10, {$urandom, $urandom});
					write_reg(REG_M11_M12, {$urandom, $urandom});
					write_reg(REG_M20_M21, {$urandom, $urandom});
					write_reg(REG_M22_T0, {$urandom, $urandom});
					write_reg(REG_T1_T2, {$urandom, $urandom});
					write_reg(REG_DEPTH_SCALE, $urandom);
					write_reg(REG_IMAGE_SIZE, {16'(h), 16'(w)});
				end
				default: begin
					// identity with the largest image, tiny image otherwise
					w = (ph < 6) ? 65535 : 2;
					h = (ph < 6) ? 65535 : 2;
					write_reg(REG_M00_M01, RST_M00_M01);
					write_reg(REG_M02_M10, RST_M02_M10);
					write_reg(REG_M11_M12, RST_M11_M12);
					write_reg(REG_M20_M21, RST_M20_M21);
					write_reg(REG_M22_T0, RST_M22_T0);
					write_reg(REG_T1_T2, RST_T1_T2);
					write_reg(REG_DEPTH_SCALE, {32'b0, RST_DEPTH_SCALE});
					write_reg(REG_IMAGE_SIZE, {16'(h), 16'(w)});
				end
			endcase
			for (int i = 0; i < 84; i++) begin
				// long receiver hold-off while pixels keep coming
				if (ph == 2 && i == 10)
					hold_req = 1'b1;
				// sender waits for the pipeline to empty mid-phase
				if (ph == 6 && i == 40) begin
					pix_ch.valid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end
				random_pixel(w, h);
			end
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
